// File: sv/ppm6_pkg.sv
// Shared types and constants of the PPM P6 header parser.
`default_nettype none

package ppm6_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_BAD_SIZE  = 3'd2,
        ST_BAD_MAX   = 3'd3,
        ST_TOO_LARGE = 3'd4
    } t_status;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;

    // maximum sample value limits
    localparam logic [16:0] MAX_LIMIT       = 17'h10000;
    localparam logic [16:0] WIDE_SAMPLE_MIN = 17'h00100;

    localparam logic [1:0] BPS_NONE = 2'd0;
    localparam logic [1:0] BPS_ONE  = 2'd1;
    localparam logic [1:0] BPS_TWO  = 2'd2;

    localparam int OUT_BYTES_W = 35;
    localparam int TDATA_OUT_W = 88;

    // end-of-header request from parser to result stage
    typedef struct packed {
        logic        valid;
        t_status     status;
        logic [15:0] max_value;
        logic [1:0]  bps;
    } t_fin;

endpackage

`default_nettype wire

// File: sv/ppm6_parser.sv
// Byte-wise header state machine: magic check, whitespace/comment skip, number parse.
`default_nettype none

module ppm6_parser #(
    parameter int DIM_BITS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire  [7:0]          i_byte,
    input  wire                 i_restart,
    output logic [DIM_BITS:0]   o_saved_width,
    output logic [DIM_BITS:0]   o_saved_height,
    output ppm6_pkg::t_fin      o_fin
);

    localparam int AW = DIM_BITS + 1;

    typedef enum logic [2:0] {
        PH_MAGIC1,
        PH_MAGIC2,
        PH_SKIP,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    t_phase          r_phase, n_phase, c_phase;
    logic            r_first_ok, n_first_ok;
    logic [1:0]      r_field, n_field;
    logic            r_in_comment, n_in_comment;
    logic [AW-1:0]   r_acc, n_acc;
    logic            r_acc_neg, n_acc_neg;
    logic [AW-1:0]   r_sw, n_sw;
    logic            r_sw_neg, n_sw_neg;
    logic [AW-1:0]   r_sh, n_sh;

    logic            is_space, is_digit;
    logic [AW+3:0]   acc_mul;
    ppm6_pkg::t_fin  fin;

    assign is_space = (i_byte == ppm6_pkg::CH_SPACE) ||
                      ((i_byte >= ppm6_pkg::CH_TAB) && (i_byte <= ppm6_pkg::CH_CR));
    assign is_digit = (i_byte >= ppm6_pkg::CH_ZERO) && (i_byte <= ppm6_pkg::CH_NINE);
    // acc * 10 + digit; low nibble of an ASCII digit is its value
    assign acc_mul  = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + {(AW)'(0), i_byte[3:0]};

    always_comb begin
        // restart forces the magic-byte phase; other state is rewritten before use
        c_phase      = i_restart ? PH_MAGIC1 : r_phase;
        n_phase      = r_phase;
        n_first_ok   = r_first_ok;
        n_field      = r_field;
        n_in_comment = r_in_comment;
        n_acc        = r_acc;
        n_acc_neg    = r_acc_neg;
        n_sw         = r_sw;
        n_sw_neg     = r_sw_neg;
        n_sh         = r_sh;
        fin          = '{valid: 1'b0, status: ppm6_pkg::ST_OK,
                         max_value: 16'd0, bps: ppm6_pkg::BPS_NONE};
        if (i_en) begin
            n_phase = c_phase;
            unique case (c_phase)
                PH_MAGIC1: begin
                    n_first_ok = (i_byte == ppm6_pkg::CH_P);
                    n_phase    = PH_MAGIC2;
                end
                PH_MAGIC2: begin
                    if (!r_first_ok || (i_byte != ppm6_pkg::CH_SIX)) begin
                        fin.valid  = 1'b1;
                        fin.status = ppm6_pkg::ST_BAD_MAGIC;
                        n_phase    = PH_DONE;
                    end else begin
                        n_field      = 2'd0;
                        n_in_comment = 1'b0;
                        n_phase      = PH_SKIP;
                    end
                end
                PH_SKIP, PH_DIGITS: begin
                    if (r_in_comment) begin
                        if (i_byte == ppm6_pkg::CH_NL) begin
                            n_in_comment = 1'b0;
                        end
                    end else if (i_byte == ppm6_pkg::CH_HASH) begin
                        n_in_comment = 1'b1;
                    end else if (c_phase == PH_SKIP) begin
                        if (!is_space) begin
                            // first char taken unchecked, signed byte minus '0'
                            if (i_byte[7] || (i_byte < ppm6_pkg::CH_ZERO)) begin
                                n_acc_neg = 1'b1;
                                n_acc     = '0;
                            end else begin
                                n_acc_neg = 1'b0;
                                n_acc     = AW'(7'(i_byte - ppm6_pkg::CH_ZERO));
                            end
                            n_phase = PH_DIGITS;
                        end
                    end else if (is_digit) begin
                        if (!r_acc_neg) begin
                            n_acc = (|acc_mul[AW+3:AW]) ? {AW{1'b1}} : acc_mul[AW-1:0];
                        end
                    end else begin
                        unique case (r_field)
                            2'd0: begin
                                n_sw     = r_acc;
                                n_sw_neg = r_acc_neg;
                                n_field  = 2'd1;
                                n_phase  = PH_SKIP;
                            end
                            2'd1: begin
                                if (r_sw_neg || (r_sw == '0) || r_acc_neg || (r_acc == '0)) begin
                                    fin.valid  = 1'b1;
                                    fin.status = ppm6_pkg::ST_BAD_SIZE;
                                    n_phase    = PH_DONE;
                                end else begin
                                    n_sh    = r_acc;
                                    n_field = 2'd2;
                                    n_phase = PH_SKIP;
                                end
                            end
                            default: begin
                                fin.valid = 1'b1;
                                n_phase   = PH_DONE;
                                if (r_acc_neg || (r_acc <= AW'(1)) ||
                                    (r_acc >= AW'(ppm6_pkg::MAX_LIMIT))) begin
                                    fin.status = ppm6_pkg::ST_BAD_MAX;
                                end else if (r_sw[DIM_BITS] || r_sh[DIM_BITS]) begin
                                    fin.status = ppm6_pkg::ST_TOO_LARGE;
                                end else begin
                                    fin.status    = ppm6_pkg::ST_OK;
                                    fin.max_value = r_acc[15:0];
                                    fin.bps       = (r_acc < AW'(ppm6_pkg::WIDE_SAMPLE_MIN)) ?
                                                    ppm6_pkg::BPS_ONE : ppm6_pkg::BPS_TWO;
                                end
                            end
                        endcase
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_MAGIC1;
            r_first_ok   <= 1'b0;
            r_field      <= 2'd0;
            r_in_comment <= 1'b0;
            r_acc        <= '0;
            r_acc_neg    <= 1'b0;
            r_sw         <= '0;
            r_sw_neg     <= 1'b0;
            r_sh         <= '0;
        end else begin
            r_phase      <= n_phase;
            r_first_ok   <= n_first_ok;
            r_field      <= n_field;
            r_in_comment <= n_in_comment;
            r_acc        <= n_acc;
            r_acc_neg    <= n_acc_neg;
            r_sw         <= n_sw;
            r_sw_neg     <= n_sw_neg;
            r_sh         <= n_sh;
        end
    end

    assign o_saved_width  = r_sw;
    assign o_saved_height = r_sh;
    assign o_fin          = fin;

endmodule

`default_nettype wire

// File: sv/ppm6_result.sv
// Result stage: registered image area, byte count and the output register.
`default_nettype none

module ppm6_result #(
    parameter int DIM_BITS = 16
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire  [DIM_BITS:0]                         i_saved_width,
    input  wire  [DIM_BITS:0]                         i_saved_height,
    input  ppm6_pkg::t_fin                            i_fin,
    input  wire                                       i_out_ready,
    output logic                                      o_out_valid,
    output logic [ppm6_pkg::TDATA_OUT_W-1:0]          o_out_data
);

    localparam int AREA_W = 2 * (DIM_BITS + 1);
    localparam int PROD_W = AREA_W + 3;

    logic [AREA_W-1:0]                     r_area;
    logic [PROD_W-1:0]                     area3, bytes_full;
    logic                                  r_valid, n_valid;
    logic [ppm6_pkg::TDATA_OUT_W-1:0]      r_data;
    logic [15:0]                           res_w, res_h;

    // width and height settle at least two bytes before the maximum ends
    always_ff @(posedge i_clk) begin
        r_area <= i_saved_width * i_saved_height;
    end

    assign area3      = {2'b00, r_area, 1'b0} + {3'b000, r_area};
    assign bytes_full = (i_fin.bps == ppm6_pkg::BPS_TWO) ? {area3[PROD_W-2:0], 1'b0} : area3;
    assign res_w      = (i_fin.status == ppm6_pkg::ST_OK) ? i_saved_width[15:0]  : 16'd0;
    assign res_h      = (i_fin.status == ppm6_pkg::ST_OK) ? i_saved_height[15:0] : 16'd0;
    assign n_valid    = i_fin.valid || (r_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fin.valid) begin
            r_data <= {(i_fin.status == ppm6_pkg::ST_OK) ?
                           bytes_full[ppm6_pkg::OUT_BYTES_W-1:0] :
                           {ppm6_pkg::OUT_BYTES_W{1'b0}},
                       i_fin.bps, i_fin.max_value, res_h, res_w, i_fin.status};
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

`default_nettype wire

// File: sv/ppm_p6_header_parser_unit.sv
// Top level of the PPM P6 header parser: input register, parser and result stage.
//
// Slave stream: one file byte per request in s_axis_tdata; s_axis_tuser = 1 restarts
// the parser and makes that byte the first magic byte.
// Master stream: one request per header (or per magic/size/maximum error), carrying
// status, width, height, maximum, bytes per sample and pixel data byte count.
// After a result every byte is swallowed without output until a restart.
// A byte is captured in the input register and parsed straight into the result
// register as soon as that register is free to take it.
// Throughput: one byte per cycle outside a stall; the limit is the parser state update.
// The image area is a registered width x height product updated every cycle.
// Reset: synchronous, active low; parser returns to the first magic byte and both
// stages empty. Reset takes effect immediately, no clearing pass.
// Stall: while a result waits and m_axis_tready is low, the byte in the input
// register holds and s_axis_tready drops; the pipeline resumes the cycle the
// result is taken, with no bubble.
`default_nettype none

module ppm_p6_header_parser_unit #(
    parameter int DIM_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire         s_axis_tuser,   // [0] restart
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [2:0] status, [18:3] image_width, [34:19] image_height, [50:35] max_value,
    // [52:51] bytes_per_sample, [87:53] pixel_data_bytes
    output logic [87:0] m_axis_tdata
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_restart;
    logic              out_free, advance;
    logic [DIM_BITS:0] saved_width, saved_height;
    ppm6_pkg::t_fin    fin;

    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte    <= s_axis_tdata;
            r_in_restart <= s_axis_tuser;
        end
    end

    ppm6_parser #(
        .DIM_BITS (DIM_BITS)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (advance),
        .i_byte         (r_in_byte),
        .i_restart      (r_in_restart),
        .o_saved_width  (saved_width),
        .o_saved_height (saved_height),
        .o_fin          (fin)
    );

    ppm6_result #(
        .DIM_BITS (DIM_BITS)
    ) u_result (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_saved_width  (saved_width),
        .i_saved_height (saved_height),
        .i_fin          (fin),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_out_data     (m_axis_tdata)
    );

endmodule

`default_nettype wire

// File: tb/sv/ppm_p6_header_parser_unit_tb.sv
// Self-checking testbench for the PPM P6 header parser with a scoreboard class.
module ppm_p6_header_parser_unit_tb;

    localparam int DIM_BITS     = 16;
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 1850;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 40;
    localparam longint TIMEOUT  = 3_000_000;

    localparam longint unsigned ACC_SAT = (64'd1 << (DIM_BITS + 1)) - 1;
    localparam longint unsigned DIM_CAP = (64'd1 << DIM_BITS) - 1;

    typedef enum int {
        PH_MAGIC1,
        PH_MAGIC2,
        PH_SKIP,
        PH_DIGITS,
        PH_DONE
    } t_parse_phase;

    // same layout as m_axis_tdata, status in the low bits
    typedef struct packed {
        logic [34:0]       pixel_bytes;
        logic [1:0]        bps;
        logic [15:0]       max_value;
        logic [15:0]       height;
        logic [15:0]       width;
        ppm6_pkg::t_status status;
    } t_header_info;

    class header_scoreboard;
        t_parse_phase    phase;
        bit              magic_p_seen;
        int unsigned     field_idx;
        bit              in_comment;
        longint unsigned acc;
        bit              acc_neg;
        longint unsigned width_acc;
        bit              width_neg;
        longint unsigned height_acc;
        t_header_info    pending[$];
        int              errors;
        int              results_seen;

        function new();
            clear_parser();
            errors       = 0;
            results_seen = 0;
        endfunction

        function void clear_parser();
            phase        = PH_MAGIC1;
            magic_p_seen = 1'b0;
            field_idx    = 0;
            in_comment   = 1'b0;
            acc          = 0;
            acc_neg      = 1'b0;
            width_acc    = 0;
            width_neg    = 1'b0;
            height_acc   = 0;
        endfunction

        function void emit(ppm6_pkg::t_status st, longint unsigned w, longint unsigned h,
                           longint unsigned m, logic [1:0] bps);
            t_header_info r;
            longint unsigned area;
            area          = 64'd3 * longint'(bps) * w * h;
            r.status      = st;
            r.width       = w[15:0];
            r.height      = h[15:0];
            r.max_value   = m[15:0];
            r.bps         = bps;
            r.pixel_bytes = area[34:0];
            pending.push_back(r);
            phase = PH_DONE;
        endfunction

        function void close_field();
            if (field_idx == 0) begin
                width_acc = acc;
                width_neg = acc_neg;
                field_idx = 1;
                phase     = PH_SKIP;
            end else if (field_idx == 1) begin
                if (width_neg || width_acc == 0 || acc_neg || acc == 0) begin
                    emit(ppm6_pkg::ST_BAD_SIZE, 0, 0, 0, ppm6_pkg::BPS_NONE);
                end else begin
                    height_acc = acc;
                    field_idx  = 2;
                    phase      = PH_SKIP;
                end
            end else if (acc_neg || acc <= 1 || acc >= ppm6_pkg::MAX_LIMIT) begin
                emit(ppm6_pkg::ST_BAD_MAX, 0, 0, 0, ppm6_pkg::BPS_NONE);
            end else if (width_acc > DIM_CAP || height_acc > DIM_CAP) begin
                emit(ppm6_pkg::ST_TOO_LARGE, 0, 0, 0, ppm6_pkg::BPS_NONE);
            end else begin
                emit(ppm6_pkg::ST_OK, width_acc, height_acc, acc,
                     (acc < ppm6_pkg::WIDE_SAMPLE_MIN) ? ppm6_pkg::BPS_ONE
                                                       : ppm6_pkg::BPS_TWO);
            end
        endfunction

        // one accepted byte request
        function void note_input(logic [7:0] b, logic restart);
            int v;
            longint unsigned nxt;
            if (restart)
                clear_parser();
            case (phase)
                PH_MAGIC1: begin
                    magic_p_seen = (b == ppm6_pkg::CH_P);
                    phase        = PH_MAGIC2;
                end
                PH_MAGIC2: begin
                    if (!magic_p_seen || b != ppm6_pkg::CH_SIX) begin
                        emit(ppm6_pkg::ST_BAD_MAGIC, 0, 0, 0, ppm6_pkg::BPS_NONE);
                    end else begin
                        field_idx  = 0;
                        in_comment = 1'b0;
                        phase      = PH_SKIP;
                    end
                end
                PH_SKIP, PH_DIGITS: begin
                    if (in_comment) begin
                        if (b == ppm6_pkg::CH_NL)
                            in_comment = 1'b0;
                    end else if (b == ppm6_pkg::CH_HASH) begin
                        in_comment = 1'b1;
                    end else if (phase == PH_SKIP) begin
                        if (!(b == ppm6_pkg::CH_SPACE ||
                              (b >= ppm6_pkg::CH_TAB && b <= ppm6_pkg::CH_CR))) begin
                            // first character is taken as a digit unchecked, signed byte
                            v = int'($signed(b)) - int'(ppm6_pkg::CH_ZERO);
                            acc_neg = (v < 0);
                            acc     = (v < 0) ? 0 : longint'(v);
                            phase   = PH_DIGITS;
                        end
                    end else if (b >= ppm6_pkg::CH_ZERO && b <= ppm6_pkg::CH_NINE) begin
                        if (!acc_neg) begin
                            nxt = acc * 10 + longint'(b - ppm6_pkg::CH_ZERO);
                            acc = (nxt > ACC_SAT) ? ACC_SAT : nxt;
                        end
                    end else begin
                        close_field();
                    end
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what, longint unsigned got, longint unsigned want);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch %s: got 0x%0h, expected 0x%0h (result %0d)",
                         what, got, want, results_seen);
        endtask

        task check_result(logic [87:0] word);
            t_header_info got;
            t_header_info want;
            got = t_header_info'(word);
            results_seen++;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", word[63:0], 0);
                return;
            end
            want = pending.pop_front();
            if (got.status != want.status)
                report_mismatch("status", got.status, want.status);
            if (got.width != want.width)
                report_mismatch("image_width", got.width, want.width);
            if (got.height != want.height)
                report_mismatch("image_height", got.height, want.height);
            if (got.max_value != want.max_value)
                report_mismatch("max_value", got.max_value, want.max_value);
            if (got.bps != want.bps)
                report_mismatch("bytes_per_sample", got.bps, want.bps);
            if (got.pixel_bytes != want.pixel_bytes)
                report_mismatch("pixel_data_bytes", got.pixel_bytes, want.pixel_bytes);
        endtask

        task check_drained();
            t_header_info want;
            while (pending.size() != 0) begin
                want = pending.pop_front();
                report_mismatch("missing result, status", 0, want.status);
            end
        endtask
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [87:0] m_axis_tdata;

    header_scoreboard sb;
    logic [8:0]  byte_q[$];   // {restart, data_byte}
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_start    = 1'b0;
    bit          hold_done     = 1'b0;

    ppm_p6_header_parser_unit #(
        .DIM_BITS(DIM_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // sample both sides with the values that held at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // result side: random stalls, plus one long hold-off to back up the input
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_start && !hold_done) begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) begin
                    m_axis_tready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic void push(logic [7:0] b, logic restart);
        byte_q.push_back({restart, b});
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push(s[i], 1'b0);
    endfunction

    function automatic logic [7:0] pick_blank();
        int unsigned r;
        r = $urandom_range(0, 5);
        return (r == 5) ? ppm6_pkg::CH_SPACE : ppm6_pkg::CH_TAB + 8'(r);
    endfunction

    function automatic void add_comment();
        logic [7:0] b;
        push(ppm6_pkg::CH_HASH, 1'b0);
        repeat ($urandom_range(0, 6)) begin
            b = 8'($urandom);
            push((b == ppm6_pkg::CH_NL) ? 8'ha5 : b, 1'b0);
        end
        push(ppm6_pkg::CH_NL, 1'b0);
    endfunction

    function automatic void add_gap();
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 3) == 0)
                add_comment();
            else
                push(pick_blank(), 1'b0);
        end
    endfunction

    function automatic void add_number(longint unsigned val);
        logic [7:0] digits[$];
        logic [7:0] b;
        if ($urandom_range(0, 7) == 0) begin
            // odd first character: any byte but '#' and whitespace, e.g. letter, punctuation or high byte
            do b = 8'($urandom);
            while (b == ppm6_pkg::CH_HASH || b == ppm6_pkg::CH_SPACE ||
                   (b >= ppm6_pkg::CH_TAB && b <= ppm6_pkg::CH_CR));
            push(b, 1'b0);
        end else if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) push(ppm6_pkg::CH_ZERO, 1'b0);
        end
        do begin
            digits.push_front(ppm6_pkg::CH_ZERO + 8'(val % 10));
            val = val / 10;
        end while (val != 0);
        foreach (digits[i]) begin
            push(digits[i], 1'b0);
            if ($urandom_range(0, 24) == 0)
                add_comment();
        end
        if ($urandom_range(0, 4) == 0) begin
            do b = 8'($urandom);
            while (b == ppm6_pkg::CH_HASH ||
                   (b >= ppm6_pkg::CH_ZERO && b <= ppm6_pkg::CH_NINE));
            push(b, 1'b0);
        end else begin
            push(pick_blank(), 1'b0);
        end
    endfunction

    function automatic longint unsigned pick_dim();
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return 1;
            2:       return 65535;
            3:       return 65536;
            4:       return $urandom_range(65537, 140000);
            5:       return $urandom_range(140000, 99999999);
            default: return $urandom_range(1, 3000);
        endcase
    endfunction

    function automatic longint unsigned pick_max();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return 255;
            4:       return 256;
            5:       return 65535;
            6:       return 65536;
            7:       return $urandom_range(65537, 9999999);
            default: return $urandom_range(3, 65534);
        endcase
    endfunction

    // queues one header attempt, returns the number of bytes it holds
    function automatic int build_header();
        logic [7:0] b;
        int unsigned cut;
        case ($urandom_range(0, 19))
            0: begin
                push(8'($urandom), 1'b1);
                repeat ($urandom_range(1, 20))
                    push(8'($urandom), ($urandom_range(0, 7) == 0));
            end
            1: begin
                b = ($urandom_range(0, 1) == 0) ? ppm6_pkg::CH_P : 8'($urandom);
                push(b, 1'b1);
                push((b != ppm6_pkg::CH_P && $urandom_range(0, 1) == 0) ?
                         ppm6_pkg::CH_SIX : 8'($urandom), 1'b0);
            end
            default: begin
                push(ppm6_pkg::CH_P, 1'b1);
                push(ppm6_pkg::CH_SIX, 1'b0);
                add_gap();
                add_number(pick_dim());
                add_gap();
                add_number(pick_dim());
                add_gap();
                add_number(pick_max());
            end
        endcase
        // broken header: cut short, the next one restarts the parser
        if ($urandom_range(0, 9) == 0 && byte_q.size() > 2) begin
            cut = $urandom_range(1, byte_q.size() - 1);
            while (byte_q.size() > cut)
                void'(byte_q.pop_back());
        end
        return byte_q.size();
    endfunction

    task automatic send_item(logic [7:0] b, logic restart);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= restart;
        do @(posedge i_clk);
        while (!s_axis_tready);
    endtask

    task automatic send_queued();
        logic [8:0] it;
        while (byte_q.size() != 0) begin
            it = byte_q.pop_front();
            send_item(it[7:0], it[8]);
        end
    endtask

    initial begin
        int sent;
        int goal;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: bad magic both ways, ignored byte after a result,
        // negative width behind a comment, too large width with maximum 2
        push(ppm6_pkg::CH_P, 1'b1);
        push_text("5");
        push_text("x");
        push(8'h51, 1'b1);
        push_text("6");
        push(ppm6_pkg::CH_P, 1'b1);
        push_text("6#\n");
        push(8'h80, 1'b0);
        push_text(" 1 ");
        push(ppm6_pkg::CH_P, 1'b1);
        push_text("6 70000\t1 2 ");
        send_queued();

        sent = 0;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 38; recv_idle_pct = 63; end
                1: begin send_idle_pct = 63; recv_idle_pct = 38; end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_start    = 1'b1;
                end
            endcase
            goal = RANDOM_ITEMS * (ph + 1) / 3;
            while (sent < goal) begin
                sent += build_header();
                // trailing bytes, mostly swallowed after a result
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) push(8'($urandom), 1'b0);
                send_queued();
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.check_drained();
        if (sb.errors == 0)
            $display("ppm_p6_header_parser_unit_tb: clean");
        else
            $display("ppm_p6_header_parser_unit_tb: errors");
        $finish;
    end

    initial begin
        #(TIMEOUT);
        $display("ppm_p6_header_parser_unit_tb: errors");
        $finish;
    end

endmodule

// File: ppm_p6_header_parser_unit.f
sv/ppm6_pkg.sv
sv/ppm6_parser.sv
sv/ppm6_result.sv
sv/ppm_p6_header_parser_unit.sv
tb/sv/ppm_p6_header_parser_unit_tb.sv
